/* rtl/hsha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hsha_pkg;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [31:0] OUTER_LEN_BITS = 32'd768;
  localparam logic [63:0] INNER_PAD_BITS = 64'd512;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    SH_PORT = 3'd0,
    SH_HELD = 3'd1,
    SH_MARK = 3'd2,
    SH_ZERO = 3'd3,
    SH_LEN  = 3'd4
  } shsel_t;

  typedef struct packed {
    logic       load_iv;
    logic       load_ikey;
    logic       load_okey;
    logic       load_dig;
    logic       save_dig;
    logic       cnt_init;
    logic       cnt_inc;
    logic       latch_byte;
    logic       shift_en;
    shsel_t     shift_sel;
    logic       start;
    logic       round;
    logic       fin;
    logic [5:0] rnd;
    logic [2:0] len_idx;
    logic [1:0] out_idx;
  } hsha_cmd_t;

  typedef struct packed {
    logic pos63;
    logic pos56;
  } hsha_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage
`default_nettype wire

/* rtl/hmac_sha256_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// HMAC-SHA256 over a byte stream with a key of up to 64 bytes held in eight
// 64-bit key registers (zero-padded, first byte in the top bits). One
// message byte is taken per transfer; a transfer with has_byte low and
// last_byte high ends the message without a byte. A byte is normally
// taken without stalling the input, and every 64th byte adds one SHA-256
// compression (setup, 64 rounds and feed-forward), during which the input
// stalls. The first transfer of a message also costs one compression for
// the inner key block. After the last transfer, padding, two or three
// compressions and the outer block finish the MAC, which comes out as four
// 64-bit words, index 0 first. No new transfer is taken until all four
// words have left.
module hmac_sha256_engine_top
  import hsha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_mac_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_word
);

  hsha_cmd_t  cmd;
  hsha_stat_t stat;

  hsha_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_has_byte    (in_has_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .stat           (stat),
    .cmd            (cmd)
  );

  hsha_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .mac_word     (out_mac_word)
  );

endmodule
`default_nettype wire

/* rtl/hsha_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module hsha_datapath
  import hsha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic [7:0]  in_data_byte,
  input  wire hsha_cmd_t   cmd,
  output hsha_stat_t       stat,
  output logic [63:0]      mac_word
);

  logic [63:0] key_r [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] dig_r [8];
  logic [63:0] cnt_r;
  logic [63:0] cnt_nxt;
  logic [5:0]  pos_r;
  logic [5:0]  pos_nxt;
  logic [7:0]  byte_r;
  logic [7:0]  sh_byte;
  logic [63:0] len_shift;
  logic [7:0]  pad;
  logic [31:0] s0, s1, ch, maj, t1, t2, g0, g1, w_new;

  assign stat.pos63 = (pos_r == 6'd63);
  assign stat.pos56 = (pos_r == 6'd56);
  assign mac_word = {h_r[{cmd.out_idx, 1'b0}], h_r[{cmd.out_idx, 1'b1}]};

  // Length byte k of the bit count, most significant byte first.
  assign len_shift = cnt_r >> {~cmd.len_idx, 3'b000};
  assign pad = cmd.load_okey ? OPAD : IPAD;

  always_comb begin
    case (cmd.shift_sel)
      SH_PORT: sh_byte = in_data_byte;
      SH_HELD: sh_byte = byte_r;
      SH_MARK: sh_byte = PAD_MARK;
      SH_LEN:  sh_byte = len_shift[7:0];
      default: sh_byte = 8'h00;
    endcase
  end

  always_comb begin
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + round_k(cmd.rnd) + w_r[0];
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + maj;
    g0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    g1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + g0 + w_r[9] + g1;
  end

  // The schedule words double as the block buffer: bytes shift in at the
  // low end, and each round shifts out the oldest word.
  always_comb begin
    w_nxt = w_r;
    if (cmd.load_ikey || cmd.load_okey) begin
      for (int i = 0; i < 16; i++) begin
        w_nxt[i] = (i[0] ? key_r[i >> 1][31:0] : key_r[i >> 1][63:32]) ^ {4{pad}};
      end
    end else if (cmd.load_dig) begin
      for (int i = 0; i < 8; i++) begin
        w_nxt[i] = dig_r[i];
        w_nxt[i + 8] = 32'h0;
      end
      w_nxt[8] = {PAD_MARK, 24'h0};
      w_nxt[15] = OUTER_LEN_BITS;
    end else if (cmd.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i + 1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], sh_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = w_new;
    end
  end

  always_comb begin
    h_nxt = h_r;
    v_nxt = v_r;
    if (cmd.load_iv) begin
      h_nxt = IV;
    end else if (cmd.fin) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end
    if (cmd.start) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (cmd.cnt_init) begin
      cnt_nxt = INNER_PAD_BITS;
      pos_nxt = 6'd0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_nxt = cnt_r + 64'd8;
      end
      if (cmd.shift_en) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        key_r[i] <= 64'h0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    v_r <= v_nxt;
    w_r <= w_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    if (cmd.latch_byte) begin
      byte_r <= in_data_byte;
    end
    if (cmd.save_dig) begin
      dig_r <= h_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/hsha_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module hsha_ctrl
  import hsha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_has_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_word_index,
  output logic            out_last_word,
  input  wire hsha_stat_t stat,
  output hsha_cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_INIT   = 12'b000000000010,
    S_CSTART = 12'b000000000100,
    S_ROUND  = 12'b000000001000,
    S_FIN    = 12'b000000010000,
    S_ABSORB = 12'b000000100000,
    S_PAD80  = 12'b000001000000,
    S_PADZ   = 12'b000010000000,
    S_PADLEN = 12'b000100000000,
    S_DIGEST = 12'b001000000000,
    S_OLOAD  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic       phase_r, phase_nxt;
  logic       has_r, has_nxt;
  logic       last_r, last_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] len_r, len_nxt;
  logic [1:0] oidx_r, oidx_nxt;
  state_t     after_byte;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 2'd3);

  always_comb begin
    cmd = '0;
    cmd.shift_sel = SH_ZERO;
    cmd.rnd = rnd_r;
    cmd.len_idx = len_r;
    cmd.out_idx = oidx_r;
    state_nxt = state_r;
    ret_nxt = ret_r;
    phase_nxt = phase_r;
    has_nxt = has_r;
    last_nxt = last_r;
    rnd_nxt = rnd_r;
    len_nxt = len_r;
    oidx_nxt = oidx_r;
    after_byte = S_IDLE;

    unique case (state_r)
      S_IDLE: begin
        after_byte = in_last_byte ? S_PAD80 : S_IDLE;
        if (in_valid && (in_has_byte || in_last_byte)) begin
          has_nxt = in_has_byte;
          last_nxt = in_last_byte;
          cmd.latch_byte = 1'b1;
          if (!phase_r) begin
            state_nxt = S_INIT;
          end else if (in_has_byte) begin
            cmd.shift_en = 1'b1;
            cmd.shift_sel = SH_PORT;
            cmd.cnt_inc = 1'b1;
            ret_nxt = after_byte;
            state_nxt = stat.pos63 ? S_CSTART : after_byte;
          end else begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_INIT: begin
        cmd.load_iv = 1'b1;
        cmd.load_ikey = 1'b1;
        cmd.cnt_init = 1'b1;
        phase_nxt = 1'b1;
        ret_nxt = S_ABSORB;
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        cmd.start = 1'b1;
        rnd_nxt = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = ret_r;
      end
      S_ABSORB: begin
        after_byte = last_r ? S_PAD80 : S_IDLE;
        if (has_r) begin
          cmd.shift_en = 1'b1;
          cmd.shift_sel = SH_HELD;
          cmd.cnt_inc = 1'b1;
          ret_nxt = after_byte;
          state_nxt = stat.pos63 ? S_CSTART : after_byte;
        end else begin
          state_nxt = S_PAD80;
        end
      end
      S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.shift_sel = SH_MARK;
        ret_nxt = S_PADZ;
        state_nxt = stat.pos63 ? S_CSTART : S_PADZ;
      end
      S_PADZ: begin
        if (stat.pos56) begin
          len_nxt = 3'd0;
          state_nxt = S_PADLEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.shift_sel = SH_ZERO;
          ret_nxt = S_PADZ;
          state_nxt = stat.pos63 ? S_CSTART : S_PADZ;
        end
      end
      S_PADLEN: begin
        cmd.shift_en = 1'b1;
        cmd.shift_sel = SH_LEN;
        len_nxt = len_r + 3'd1;
        if (len_r == 3'd7) begin
          ret_nxt = S_DIGEST;
          state_nxt = S_CSTART;
        end
      end
      S_DIGEST: begin
        cmd.save_dig = 1'b1;
        cmd.load_iv = 1'b1;
        cmd.load_okey = 1'b1;
        ret_nxt = S_OLOAD;
        state_nxt = S_CSTART;
      end
      S_OLOAD: begin
        cmd.load_dig = 1'b1;
        oidx_nxt = 2'd0;
        ret_nxt = S_OUT;
        state_nxt = S_CSTART;
      end
      S_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            phase_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      phase_r <= 1'b0;
      oidx_r <= 2'd0;
      rnd_r <= 6'd0;
      len_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      phase_r <= phase_nxt;
      oidx_r <= oidx_nxt;
      rnd_r <= rnd_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    has_r <= has_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

/* rtl/hsha_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module hsha_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_word_index,
  input wire logic       out_last_word
);

  // No input transfer while the MAC is being handed out.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while MAC words pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index))
    else $error("stalled MAC word changed");

  // Words follow in order without a gap until the last one.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 2'd1))
    else $error("MAC words out of sequence");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last word flag does not match index");

endmodule

bind hmac_sha256_engine_top hsha_checker u_hsha_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);
`default_nettype wire
